// File: rtl/csvqs_pkg.sv
// Types, codes and constants shared by the CSV field splitter modules.
package csvqs_pkg;

   localparam logic [7:0] CH_COMMA         = 8'h2C;
   localparam logic [7:0] CH_QUOTE         = 8'h22;
   localparam logic [7:0] CH_NONE          = 8'h00;
   localparam logic [5:0] MAX_FIELDS_RESET = 6'd15;
   localparam logic [5:0] FIELDS_SAT       = 6'd63;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_HELD   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_FIELD = 2'd1,
      KIND_LINE  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_out;
      logic [5:0]  field_index;
      logic [5:0]  field_count;
      logic        last_result;
   } result_type;

   typedef struct packed {
      logic [1:0]  num_results;
      result_type  res0;
      result_type  res1;
      mode_type    mode_next;
      logic [5:0]  fields_done_next;
   } step_type;

endpackage

// File: rtl/csvqs_step.sv
// Parse step: next parser state and up to two results for one character or line end.
module csvqs_step
   import csvqs_pkg::*;
(
   input  mode_type    mode,
   input  logic [5:0]  fields_done,
   input  logic [5:0]  max_fields,
   input  logic [7:0]  char_in,
   input  logic        end_of_line,
   output step_type    step
);

   logic [5:0]  fields_inc;
   result_type  field_end;
   result_type  line_end_prev;
   result_type  line_end_cur;
   result_type  char_res;
   result_type  quote_res;

   always_comb begin
      fields_inc    = (fields_done < FIELDS_SAT) ? fields_done + 6'd1 : fields_done;
      field_end     = '{kind: KIND_FIELD, char_out: CH_NONE, field_index: fields_done,
                        field_count: 6'd0, last_result: 1'b0};
      line_end_cur  = '{kind: KIND_LINE, char_out: CH_NONE, field_index: 6'd0,
                        field_count: fields_done, last_result: 1'b0};
      // line end that follows a field end sees the incremented count
      line_end_prev = '{kind: KIND_LINE, char_out: CH_NONE, field_index: 6'd0,
                        field_count: fields_inc, last_result: 1'b0};
      char_res      = '{kind: KIND_CHAR, char_out: char_in, field_index: fields_done,
                        field_count: 6'd0, last_result: 1'b0};
      quote_res     = '{kind: KIND_CHAR, char_out: CH_QUOTE, field_index: fields_done,
                        field_count: 6'd0, last_result: 1'b0};

      step                  = '0;
      step.mode_next        = mode;
      step.fields_done_next = fields_done;

      case (mode)
         MODE_START: begin
            if (end_of_line) begin
               step.num_results      = 2'd1;
               step.res0             = line_end_cur;
               step.fields_done_next = 6'd0;
            end else if (fields_done >= max_fields) begin
               // limit reached: drop the character
               step.num_results = 2'd0;
            end else if (char_in == CH_QUOTE) begin
               step.mode_next = MODE_QUOTED;
            end else if (char_in == CH_COMMA) begin
               step.num_results      = 2'd1;
               step.res0             = field_end;
               step.fields_done_next = fields_inc;
            end else begin
               step.num_results = 2'd1;
               step.res0        = char_res;
               step.mode_next   = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            if (end_of_line) begin
               step.num_results      = 2'd2;
               step.res0             = field_end;
               step.res1             = line_end_prev;
               step.mode_next        = MODE_START;
               step.fields_done_next = 6'd0;
            end else if (char_in == CH_COMMA) begin
               step.num_results      = 2'd1;
               step.res0             = field_end;
               step.mode_next        = MODE_START;
               step.fields_done_next = fields_inc;
            end else begin
               step.num_results = 2'd1;
               step.res0        = char_res;
            end
         end
         MODE_QUOTED: begin
            if (end_of_line) begin
               step.num_results      = 2'd2;
               step.res0             = field_end;
               step.res1             = line_end_prev;
               step.mode_next        = MODE_START;
               step.fields_done_next = 6'd0;
            end else if (char_in == CH_QUOTE) begin
               step.mode_next = MODE_HELD;
            end else begin
               step.num_results = 2'd1;
               step.res0        = char_res;
            end
         end
         MODE_HELD: begin
            if (end_of_line) begin
               step.num_results      = 2'd2;
               step.res0             = field_end;
               step.res1             = line_end_prev;
               step.mode_next        = MODE_START;
               step.fields_done_next = 6'd0;
            end else if (char_in == CH_COMMA) begin
               step.num_results      = 2'd1;
               step.res0             = field_end;
               step.mode_next        = MODE_START;
               step.fields_done_next = fields_inc;
            end else if (char_in == CH_QUOTE) begin
               // emit the held quote, keep holding the new one
               step.num_results = 2'd1;
               step.res0        = quote_res;
            end else begin
               step.num_results = 2'd2;
               step.res0        = quote_res;
               step.res1        = char_res;
               step.mode_next   = MODE_QUOTED;
            end
         end
         default: begin
            step.mode_next = MODE_START;
         end
      endcase

      if (step.num_results == 2'd1) begin
         step.res0.last_result = 1'b1;
      end
      if (step.num_results == 2'd2) begin
         step.res1.last_result = 1'b1;
      end
   end

endmodule

// File: rtl/csv_quoted_field_splitter.sv
// Top level of the CSV field splitter: parser state, result queue and stream ports.
//
// Usage: feed one line as a stream of characters on req_ (req_tdata = character,
// req_tlast = 1 for the end-of-line marker, whose data is ignored). Results come
// out on rsp_: rsp_tuser is the kind (content character, field end, line end),
// rsp_tdata carries the character, field index and field count, rsp_tlast marks
// the final result caused by one input transaction. An input transaction yields
// zero, one or two results.
// Results pass through the registered result queue; rsp_ offers the queue head.
// Throughput: one character per cycle while req_tready is high; a character that
// yields two results puts both into the four-entry result queue, which absorbs them.
// req_tready is high while the queue has room for two results, so a stalled
// receiver fills the queue and then holds off the sender; nothing is dropped.
// csr_wr_en writes max_fields; write it only while the block is idle.
// Reset clears the queue, returns the parser to field start with no fields
// counted and sets max_fields to 15.
module csv_quoted_field_splitter
   import csvqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_out, [13:8] field_index,
                                    // [19:14] field_count, [23:20] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last_result
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data  // [5:0] max_fields
);

   mode_type    mode_ff, mode_in;
   logic [5:0]  fields_done_ff, fields_done_in;
   logic [5:0]  max_fields_ff, max_fields_in;
   result_type  queue_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        req_fire;
   logic        rsp_fire;
   logic [1:0]  push_num;
   step_type    step;
   result_type  head;

   csvqs_step u_step (
      .mode        (mode_ff),
      .fields_done (fields_done_ff),
      .max_fields  (max_fields_ff),
      .char_in     (req_tdata),
      .end_of_line (req_tlast),
      .step        (step)
   );

   assign req_tready = (count_ff <= 3'd2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tdata  = {4'd0, head.field_count, head.field_index, head.char_out};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_result;

   always_comb begin
      push_num       = req_fire ? step.num_results : 2'd0;
      mode_in        = req_fire ? step.mode_next : mode_ff;
      fields_done_in = req_fire ? step.fields_done_next : fields_done_ff;
      max_fields_in  = csr_wr_en ? csr_wr_data : max_fields_ff;
      wr_ptr_in      = wr_ptr_ff + push_num;
      rd_ptr_in      = rsp_fire ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in       = count_ff + {1'b0, push_num} - {2'd0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_START;
         fields_done_ff <= 6'd0;
         max_fields_ff  <= MAX_FIELDS_RESET;
         wr_ptr_ff      <= 2'd0;
         rd_ptr_ff      <= 2'd0;
         count_ff       <= 3'd0;
      end else begin
         mode_ff        <= mode_in;
         fields_done_ff <= fields_done_in;
         max_fields_ff  <= max_fields_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // queue payload: write the first result at the tail, the second one after it
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= step.res0;
      end
      if (push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= step.res1;
      end
   end

endmodule
